FILE: design/bua_pkg.sv
// Shared widths, register indexes and control types for the bilinear upscale blender.
`timescale 1ns / 1ps
`default_nettype none
package bua_pkg;

  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
  localparam int unsigned DST_MAX     = 4096;

  localparam logic [8:0]  SRC_DIM_MAX = 9'd256;
  localparam logic [12:0] DST_DIM_MAX = 13'(DST_MAX);
  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [8:0]  ONE_Q8      = 9'd256;

  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_STEP_X     = 3'd4;
  localparam logic [2:0] REG_STEP_Y     = 3'd5;
  localparam logic [2:0] REG_BLEND      = 3'd6;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_BLEND = 1'b1;

  typedef struct packed {
    logic lerp_x;
    logic lerp_y;
    logic mix;
  } stage_en_t;

endpackage
`default_nettype wire

FILE: design/bilinear_upscale_alpha_blend.sv
// Top level: source pixel store, position sequencer and three channel datapaths.
// A load request leaves busy low, so the next request may follow at once.
// A blend request passes position, base, four neighbor reads through the single
// store read port, a wait state and the three arithmetic stages before done_o.
// Results appear for one cycle on done_o; the receiver cannot stall the block.
// Reset clears the counters and the registers to defaults; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_upscale_alpha_blend (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        cmd_i,
  input  wire logic [7:0]  pix_blue_i,
  input  wire logic [7:0]  pix_green_i,
  input  wire logic [7:0]  pix_red_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  output logic             done_o,
  output logic [7:0]       out_blue_o,
  output logic [7:0]       out_green_o,
  output logic [7:0]       out_red_o,
  output logic             end_of_row_o,
  output logic             end_of_frame_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_POS, ST_BASE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_WAIT, ST_LX, ST_LY, ST_MIX
  } state_e;

  state_e state_q;

  logic [8:0]  src_width_q, src_height_q, blend_ratio_q;
  logic [12:0] dst_width_q, dst_height_q;
  logic [16:0] step_x_q, step_y_q;
  logic [15:0] load_index_q;
  logic [11:0] out_col_q, out_row_q;
  logic        done_q, eor_q, eof_q;

  logic [23:0] mem_q [0:bua_pkg::STORE_DEPTH-1];
  logic [23:0] rd_q, p00_q, p10_q, p01_q, pix_q;
  logic        mem_we;
  logic [15:0] mem_raddr;

  logic [8:0]  sw, sh, ratio;
  logic [12:0] dw, dh;
  logic [16:0] stx, sty;
  logic [16:0] total, li_eff, li_next;
  logic [11:0] col, row;
  logic        accept, eor, eof;

  logic [28:0] sx_q, sy_q;
  logic [12:0] xi, yi;
  logic [7:0]  x0, x1, y0, y1;
  logic [7:0]  x0_q, x1_q, y0_q, y1_q;
  logic [15:0] fx_q, fy_q;
  logic [15:0] base0_q, base1_q;
  bua_pkg::stage_en_t en;

  assign cfg_ready_o    = 1'b1;
  assign busy_o         = (state_q != ST_IDLE);
  assign accept         = start_i && (state_q == ST_IDLE);
  assign done_o         = done_q;
  assign end_of_row_o   = eor_q;
  assign end_of_frame_o = eof_q;

  assign sw    = (src_width_q == 9'd0) ? 9'd1 :
                 (src_width_q > bua_pkg::SRC_DIM_MAX) ? bua_pkg::SRC_DIM_MAX : src_width_q;
  assign sh    = (src_height_q == 9'd0) ? 9'd1 :
                 (src_height_q > bua_pkg::SRC_DIM_MAX) ? bua_pkg::SRC_DIM_MAX : src_height_q;
  assign dw    = (dst_width_q == 13'd0) ? 13'd1 :
                 (dst_width_q > bua_pkg::DST_DIM_MAX) ? bua_pkg::DST_DIM_MAX : dst_width_q;
  assign dh    = (dst_height_q == 13'd0) ? 13'd1 :
                 (dst_height_q > bua_pkg::DST_DIM_MAX) ? bua_pkg::DST_DIM_MAX : dst_height_q;
  assign stx   = (step_x_q > bua_pkg::ONE_Q16) ? bua_pkg::ONE_Q16 : step_x_q;
  assign sty   = (step_y_q > bua_pkg::ONE_Q16) ? bua_pkg::ONE_Q16 : step_y_q;
  assign ratio = (blend_ratio_q > bua_pkg::ONE_Q8) ? bua_pkg::ONE_Q8 : blend_ratio_q;

  assign total   = 17'(sw * sh);
  assign li_eff  = ({1'b0, load_index_q} >= total) ? 17'd0 : {1'b0, load_index_q};
  assign li_next = ((li_eff + 17'd1) >= total) ? 17'd0 : li_eff + 17'd1;

  // Counters left beyond a shrunk frame count as the last position.
  assign col = ({1'b0, out_col_q} >= dw) ? 12'(dw - 13'd1) : out_col_q;
  assign row = ({1'b0, out_row_q} >= dh) ? 12'(dh - 13'd1) : out_row_q;
  assign eor = ({1'b0, out_col_q} >= (dw - 13'd1));
  assign eof = eor && ({1'b0, out_row_q} >= (dh - 13'd1));

  assign xi = sx_q[28:16];
  assign yi = sy_q[28:16];
  assign x0 = (xi >= {4'd0, sw}) ? 8'(sw - 9'd1) : xi[7:0];
  assign y0 = (yi >= {4'd0, sh}) ? 8'(sh - 9'd1) : yi[7:0];
  assign x1 = (({1'b0, x0} + 9'd1) >= sw) ? 8'(sw - 9'd1) : x0 + 8'd1;
  assign y1 = (({1'b0, y0} + 9'd1) >= sh) ? 8'(sh - 9'd1) : y0 + 8'd1;

  assign mem_we = accept && (cmd_i == bua_pkg::CMD_LOAD);

  always_comb begin
    case (state_q)
      ST_RD0:  mem_raddr = base0_q + {8'd0, x0_q};
      ST_RD1:  mem_raddr = base0_q + {8'd0, x1_q};
      ST_RD2:  mem_raddr = base1_q + {8'd0, x0_q};
      ST_RD3:  mem_raddr = base1_q + {8'd0, x1_q};
      default: mem_raddr = base0_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[li_eff[15:0]] <= {pix_red_i, pix_green_i, pix_blue_i};
    end
    rd_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= {pix_red_i, pix_green_i, pix_blue_i};
      sx_q  <= 29'(col * stx);
      sy_q  <= 29'(row * sty);
    end
    if (state_q == ST_POS) begin
      x0_q <= x0;
      x1_q <= x1;
      y0_q <= y0;
      y1_q <= y1;
      fx_q <= sx_q[15:0];
      fy_q <= sy_q[15:0];
    end
    if (state_q == ST_BASE) begin
      base0_q <= 16'(y0_q * sw);
      base1_q <= 16'(y1_q * sw);
    end
    if (state_q == ST_RD1) p00_q <= rd_q;
    if (state_q == ST_RD2) p10_q <= rd_q;
    if (state_q == ST_RD3) p01_q <= rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q   <= 9'd1;
      src_height_q  <= 9'd1;
      dst_width_q   <= 13'd1;
      dst_height_q  <= 13'd1;
      step_x_q      <= bua_pkg::ONE_Q16;
      step_y_q      <= bua_pkg::ONE_Q16;
      blend_ratio_q <= 9'd128;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bua_pkg::REG_SRC_WIDTH:  src_width_q   <= cfg_data_i[8:0];
        bua_pkg::REG_SRC_HEIGHT: src_height_q  <= cfg_data_i[8:0];
        bua_pkg::REG_DST_WIDTH:  dst_width_q   <= cfg_data_i[12:0];
        bua_pkg::REG_DST_HEIGHT: dst_height_q  <= cfg_data_i[12:0];
        bua_pkg::REG_STEP_X:     step_x_q      <= cfg_data_i;
        bua_pkg::REG_STEP_Y:     step_y_q      <= cfg_data_i;
        bua_pkg::REG_BLEND:      blend_ratio_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      load_index_q <= 16'd0;
      out_col_q    <= 12'd0;
      out_row_q    <= 12'd0;
      done_q       <= 1'b0;
      eor_q        <= 1'b0;
      eof_q        <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept && (cmd_i == bua_pkg::CMD_LOAD)) begin
            load_index_q <= li_next[15:0];
          end else if (accept) begin
            eor_q     <= eor;
            eof_q     <= eof;
            out_col_q <= eor ? 12'd0 : out_col_q + 12'd1;
            if (eor) begin
              out_row_q <= eof ? 12'd0 : out_row_q + 12'd1;
            end
            state_q <= ST_POS;
          end
        end
        ST_POS:  state_q <= ST_BASE;
        ST_BASE: state_q <= ST_RD0;
        ST_RD0:  state_q <= ST_RD1;
        ST_RD1:  state_q <= ST_RD2;
        ST_RD2:  state_q <= ST_RD3;
        ST_RD3:  state_q <= ST_WAIT;
        ST_WAIT: state_q <= ST_LX;
        ST_LX:   state_q <= ST_LY;
        ST_LY:   state_q <= ST_MIX;
        ST_MIX: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // The fourth neighbor is still in the read register when the horizontal lerp runs.
  assign en.lerp_x = (state_q == ST_WAIT);
  assign en.lerp_y = (state_q == ST_LX);
  assign en.mix    = (state_q == ST_LY);

  bua_lerp u_lerp_blue (
    .clk_i   (clk_i),
    .en_i    (en),
    .p00_i   (p00_q[7:0]),
    .p10_i   (p10_q[7:0]),
    .p01_i   (p01_q[7:0]),
    .p11_i   (rd_q[7:0]),
    .fx_i    (fx_q),
    .fy_i    (fy_q),
    .pix_i   (pix_q[7:0]),
    .ratio_i (ratio),
    .out_o   (out_blue_o)
  );

  bua_lerp u_lerp_green (
    .clk_i   (clk_i),
    .en_i    (en),
    .p00_i   (p00_q[15:8]),
    .p10_i   (p10_q[15:8]),
    .p01_i   (p01_q[15:8]),
    .p11_i   (rd_q[15:8]),
    .fx_i    (fx_q),
    .fy_i    (fy_q),
    .pix_i   (pix_q[15:8]),
    .ratio_i (ratio),
    .out_o   (out_green_o)
  );

  bua_lerp u_lerp_red (
    .clk_i   (clk_i),
    .en_i    (en),
    .p00_i   (p00_q[23:16]),
    .p10_i   (p10_q[23:16]),
    .p01_i   (p01_q[23:16]),
    .p11_i   (rd_q[23:16]),
    .fx_i    (fx_q),
    .fy_i    (fy_q),
    .pix_i   (pix_q[23:16]),
    .ratio_i (ratio),
    .out_o   (out_red_o)
  );

endmodule
`default_nettype wire

FILE: design/bua_lerp.sv
// One color channel: horizontal lerp, vertical lerp and blend, one registered stage each.
`timescale 1ns / 1ps
`default_nettype none
module bua_lerp (
  input  wire logic               clk_i,
  input  wire bua_pkg::stage_en_t en_i,
  input  wire logic [7:0]         p00_i,
  input  wire logic [7:0]         p10_i,
  input  wire logic [7:0]         p01_i,
  input  wire logic [7:0]         p11_i,
  input  wire logic [15:0]        fx_i,
  input  wire logic [15:0]        fy_i,
  input  wire logic [7:0]         pix_i,
  input  wire logic [8:0]         ratio_i,
  output logic      [7:0]         out_o
);

  logic [24:0] top_q, bot_q;
  logic [40:0] smp_q;
  logic [16:0] wfx, wfy;
  logic [8:0]  inv_r;
  logic [48:0] acc;

  assign wfx   = bua_pkg::ONE_Q16 - {1'b0, fx_i};
  assign wfy   = bua_pkg::ONE_Q16 - {1'b0, fy_i};
  assign inv_r = bua_pkg::ONE_Q8 - ratio_i;

  // The streamed pixel term sits 32 bits up so both terms share the Q8.40 scale.
  assign acc = {1'b0, 16'(pix_i * ratio_i), 32'd0} + 49'(smp_q * inv_r);

  always_ff @(posedge clk_i) begin
    if (en_i.lerp_x) begin
      top_q <= 25'(p00_i * wfx) + 25'(p10_i * {1'b0, fx_i});
      bot_q <= 25'(p01_i * wfx) + 25'(p11_i * {1'b0, fx_i});
    end
    if (en_i.lerp_y) begin
      smp_q <= 41'(top_q * wfy) + 41'(bot_q * {1'b0, fy_i});
    end
    if (en_i.mix) begin
      out_o <= acc[47:40];
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the bilinear upscale alpha blender.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       eor;
    logic       eof;
  } blend_pixel_t;

  class blend_scoreboard;
    logic [23:0]  pixel_store [bua_pkg::STORE_DEPTH];
    int unsigned  load_idx, out_col, out_row;
    logic [8:0]   src_w, src_h, ratio;
    logic [12:0]  dst_w, dst_h;
    logic [16:0]  step_x, step_y;
    blend_pixel_t expected_pixels [$];
    int unsigned  mismatches, blends_checked, loads_seen;

    function void set_register(logic [2:0] idx, logic [16:0] value);
      case (idx)
        bua_pkg::REG_SRC_WIDTH:  src_w  = value[8:0];
        bua_pkg::REG_SRC_HEIGHT: src_h  = value[8:0];
        bua_pkg::REG_DST_WIDTH:  dst_w  = value[12:0];
        bua_pkg::REG_DST_HEIGHT: dst_h  = value[12:0];
        bua_pkg::REG_STEP_X:     step_x = value;
        bua_pkg::REG_STEP_Y:     step_y = value;
        bua_pkg::REG_BLEND:      ratio  = value[8:0];
        default: ;
      endcase
    endfunction

    function void clear();
      load_idx = 0; out_col = 0; out_row = 0;
      src_w = 1; src_h = 1; dst_w = 1; dst_h = 1;
      step_x = bua_pkg::ONE_Q16; step_y = bua_pkg::ONE_Q16; ratio = 128;
    endfunction

    function int unsigned fit(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function int unsigned src_pixels();
      return fit(src_w, 256) * fit(src_h, 256);
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    function void note_request(logic cmd, logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int unsigned sw, sh, dw, dh, stx, sty, rt, col, row, x0, y0, x1, y1;
      longint unsigned sx, sy, fx, fy, top, bot, smp, acc;
      logic [23:0] p00, p10, p01, p11, pix;
      blend_pixel_t e;
      sw = fit(src_w, 256);
      sh = fit(src_h, 256);
      pix = {r, g, b};
      if (cmd == bua_pkg::CMD_LOAD) begin
        loads_seen++;
        if (load_idx >= sw * sh) load_idx = 0;
        pixel_store[load_idx % bua_pkg::STORE_DEPTH] = pix;
        load_idx++;
        if (load_idx >= sw * sh) load_idx = 0;
        return;
      end
      dw = fit(dst_w, bua_pkg::DST_MAX);
      dh = fit(dst_h, bua_pkg::DST_MAX);
      stx = (step_x > bua_pkg::ONE_Q16) ? bua_pkg::ONE_Q16 : step_x;
      sty = (step_y > bua_pkg::ONE_Q16) ? bua_pkg::ONE_Q16 : step_y;
      rt = (ratio > bua_pkg::ONE_Q8) ? bua_pkg::ONE_Q8 : ratio;
      col = (out_col >= dw) ? dw - 1 : out_col;
      row = (out_row >= dh) ? dh - 1 : out_row;
      sx = longint'(col) * stx;
      sy = longint'(row) * sty;
      fx = sx & 64'hFFFF;
      fy = sy & 64'hFFFF;
      x0 = ((sx >> 16) >= sw) ? sw - 1 : int'(sx >> 16);
      y0 = ((sy >> 16) >= sh) ? sh - 1 : int'(sy >> 16);
      x1 = (x0 + 1 >= sw) ? sw - 1 : x0 + 1;
      y1 = (y0 + 1 >= sh) ? sh - 1 : y0 + 1;
      p00 = pixel_store[(y0 * sw + x0) % bua_pkg::STORE_DEPTH];
      p10 = pixel_store[(y0 * sw + x1) % bua_pkg::STORE_DEPTH];
      p01 = pixel_store[(y1 * sw + x0) % bua_pkg::STORE_DEPTH];
      p11 = pixel_store[(y1 * sw + x1) % bua_pkg::STORE_DEPTH];
      for (int k = 0; k < 3; k++) begin
        top = longint'(p00[8*k +: 8]) * (65536 - fx) + longint'(p10[8*k +: 8]) * fx;
        bot = longint'(p01[8*k +: 8]) * (65536 - fx) + longint'(p11[8*k +: 8]) * fx;
        smp = top * (65536 - fy) + bot * fy;
        acc = ((longint'(pix[8*k +: 8]) * rt) << 32) + smp * (256 - rt);
        case (k)
          0: e.blue  = acc[47:40];
          1: e.green = acc[47:40];
          default: e.red = acc[47:40];
        endcase
      end
      e.eor = (out_col >= dw - 1);
      e.eof = e.eor && (out_row >= dh - 1);
      if (e.eor) begin
        out_col = 0;
        out_row = e.eof ? 0 : out_row + 1;
      end else begin
        out_col++;
      end
      expected_pixels.push_back(e);
    endfunction

    function void check_result(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                               logic eor, logic eof);
      blend_pixel_t e;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: blue %0d green %0d red %0d", b, g, r);
        mismatches++;
        return;
      end
      e = expected_pixels.pop_front();
      blends_checked++;
      if (b !== e.blue) begin
        $error("out_blue: expected %0d, actual %0d", e.blue, b); mismatches++;
      end
      if (g !== e.green) begin
        $error("out_green: expected %0d, actual %0d", e.green, g); mismatches++;
      end
      if (r !== e.red) begin
        $error("out_red: expected %0d, actual %0d", e.red, r); mismatches++;
      end
      if (eor !== e.eor) begin
        $error("end_of_row: expected %0d, actual %0d", e.eor, eor); mismatches++;
      end
      if (eof !== e.eof) begin
        $error("end_of_frame: expected %0d, actual %0d", e.eof, eof); mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        cmd_i = bua_pkg::CMD_LOAD;
  logic [7:0]  pix_blue_i = '0, pix_green_i = '0, pix_red_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic [2:0]  cfg_index_i = bua_pkg::REG_SRC_WIDTH;
  logic [16:0] cfg_data_i = '0;
  logic        busy_o, cfg_ready_o, done_o, end_of_row_o, end_of_frame_o;
  logic [7:0]  out_blue_o, out_green_o, out_red_o;

  blend_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned blends_sent = 0;
  int unsigned items_sent = 0;
  int unsigned phases_run = 0;
  bit          gaps_on = 1'b1;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  bilinear_upscale_alpha_blend u_dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) sb.note_request(cmd_i, pix_blue_i, pix_green_i, pix_red_i);
    if (rst_ni && done_o)
      sb.check_result(out_blue_o, out_green_o, out_red_o, end_of_row_o, end_of_frame_o);
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function int unsigned gap_len();
    int unsigned dice;
    dice = $urandom_range(99);
    if (!gaps_on || dice < 65) return 0;
    if (dice < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function logic [7:0] rand_channel();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_request(logic cmd);
    int unsigned gap;
    start_i     <= 1'b1;
    cmd_i       <= cmd;
    pix_blue_i  <= rand_channel();
    pix_green_i <= rand_channel();
    pix_red_i   <= rand_channel();
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    if (cmd == bua_pkg::CMD_BLEND) blends_sent++;
    gap = gap_len();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the sender until every blend is back, then lets the pipeline drain.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (14) @(posedge clk_i);
  endtask

  task automatic write_register(logic [2:0] idx, logic [16:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk_i);
  endtask

  // One setting: program all registers, fill the source image, then mixed traffic.
  // A full run of loads writes every pixel once, wherever the load index starts.
  task automatic run_setting(logic [16:0] sw, logic [16:0] sh, logic [16:0] dw,
                             logic [16:0] dh, logic [16:0] stx, logic [16:0] sty,
                             logic [16:0] rt, int unsigned n_blends);
    int unsigned fill;
    drain();
    write_register(bua_pkg::REG_SRC_WIDTH, sw);
    write_register(bua_pkg::REG_SRC_HEIGHT, sh);
    write_register(bua_pkg::REG_DST_WIDTH, dw);
    write_register(bua_pkg::REG_DST_HEIGHT, dh);
    write_register(bua_pkg::REG_STEP_X, stx);
    write_register(bua_pkg::REG_STEP_Y, sty);
    write_register(bua_pkg::REG_BLEND, rt);
    fill = sb.src_pixels();
    repeat (fill) send_request(bua_pkg::CMD_LOAD);
    for (int i = 0; i < n_blends; i++) begin
      send_request(($urandom_range(9) == 0) ? bua_pkg::CMD_LOAD : bua_pkg::CMD_BLEND);
      if ($urandom_range(60) == 0) drain();
    end
    phases_run++;
  endtask

  function logic [16:0] rand_step();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return bua_pkg::ONE_Q16;
      2: return 17'h1FFFF;
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  function logic [16:0] rand_ratio();
    case ($urandom_range(4))
      0: return 17'd0;
      1: return 17'd256;
      2: return 17'h1FF;
      default: return 17'($urandom_range(256));
    endcase
  endfunction

  initial begin
    sb.clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    // Defaults after reset: one-pixel source and destination.
    send_request(bua_pkg::CMD_LOAD);
    repeat (3) send_request(bua_pkg::CMD_BLEND);
    run_setting(2, 2, 4, 4, 17'h8000, 17'h8000, 0, 8);
    run_setting(2, 2, 3, 5, 17'h5555, 17'hC000, 256, 6);
    // Out-of-range sizes, steps and ratio, with the widest source row.
    run_setting(511, 0, 8191, 0, 17'h1FFFF, 17'h1FFFF, 17'h1FF, 5);
    while (items_sent < 600) begin
      gaps_on = ($urandom_range(4) != 0);
      run_setting(17'($urandom_range(8, 1)), 17'($urandom_range(8, 1)),
                  ($urandom_range(9) == 0) ? 17'd4096 : 17'($urandom_range(20, 1)),
                  17'($urandom_range(12, 1)), rand_step(), rand_step(), rand_ratio(),
                  $urandom_range(60, 20));
    end
    drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d settings and %0d requests: %0d loads, %0d blends sent.",
             phases_run, items_sent, sb.loads_seen, blends_sent);
    $display("Checked %0d blended pixels against the predictor.", sb.blends_checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: files.f
design/bua_pkg.sv
design/bua_lerp.sv
design/bilinear_upscale_alpha_blend.sv
tb/sv/testbench.sv
